// ===== rtl/lzd_pkg.sv =====
// shared types and constants of the lzss stream decoder
package lzd_pkg;

    localparam int BYTE_W = 8;
    // wide enough for the largest raw match length (63 + 2 + 1 with the default parameters)
    localparam int LEN_SUM_W = 9;

    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_HIGH  = 2'd2;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] data;
    } out_word_t;

endpackage

// ===== rtl/lzss_stream_decoder.sv =====
// lzss stream decoder top level: token parser, window copy engine, output queue
//
//  side    | ports                      | word
//  --------+----------------------------+--------------------------------------
//  slave   | s_tvalid s_tready s_tdata  | tdata: in_byte; tuser: stream_start
//          | s_tuser                    |
//  master  | m_tvalid m_tready m_tdata  | tdata: dec_byte; tlast: run_last
//          | m_tlast                    |
//
// flag bytes, match low bytes and literals start no copy; a match high byte
// holds the slave side until its copy is done: the copy engine reads the
// window ram one byte per cycle while the output queue has room, registered read
// after reset a clearing pass zeroes the window, s_tready low
// a stalled master side stops the copy engine once the two-entry queue is full
module lzss_stream_decoder
    import lzd_pkg::*;
#(
    parameter int WINDOW_SIZE = 1024,
    parameter int MAX_MATCH   = 64,
    parameter int OFFSET_BITS = 10,
    parameter int MIN_MATCH   = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic [0:0]        s_tuser,   // [0] stream_start
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] dec_byte
    output logic              m_tlast    // run_last
);

    localparam int WIN_AW = $clog2(WINDOW_SIZE);
    localparam int LEN_W  = $clog2(MAX_MATCH + 1);
    localparam logic [WIN_AW-1:0] WP_START = WIN_AW'(WINDOW_SIZE - MAX_MATCH);

    logic              clr_active_reg, clr_active_next;
    logic [WIN_AW-1:0] clr_addr_reg, clr_addr_next;
    logic [WIN_AW-1:0] wp_reg, wp_next;
    logic [7:0]        flag_bits_reg, flag_bits_next;
    logic [3:0]        flags_left_reg, flags_left_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        match_low_reg, match_low_next;
    logic [LEN_W-1:0]  copy_left_reg, copy_left_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_last_reg, rd_last_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [BYTE_W-1:0] fwd_data_reg, fwd_data_next;

    logic              in_acc, pop, issue, credit_ok, lit_push, push;
    logic [1:0]        fifo_cnt;
    logic [1:0]        phase_eff;
    logic [3:0]        fl_dec;
    logic [15:0]       match_word;
    logic [LEN_SUM_W-1:0] len_raw;
    logic [LEN_W-1:0]  len_sat;
    logic [WIN_AW-1:0] rd_addr;
    logic [BYTE_W-1:0] ram_rdata, ram_byte;
    logic              ram_we;
    logic [WIN_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    out_word_t         push_word, head_word;

    assign in_acc    = s_tvalid & s_tready;
    assign pop       = m_tvalid & m_tready;
    assign credit_ok = (3'(fifo_cnt) + 3'(rd_pend_reg)) < (3'd2 + 3'(pop));
    assign issue     = (copy_left_reg != '0) && credit_ok && !clr_active_reg;
    assign rd_addr   = WIN_AW'(pos_reg);
    assign ram_byte  = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign push      = rd_pend_reg | lit_push;

    assign s_tready = !clr_active_reg && (copy_left_reg == '0) && !rd_pend_reg
                      && (fifo_cnt != 2'd2);

    assign match_word = {s_tdata, match_low_reg};
    assign len_raw    = LEN_SUM_W'(match_word[15:OFFSET_BITS]) + LEN_SUM_W'(MIN_MATCH + 1);
    assign len_sat    = (len_raw > LEN_SUM_W'(MAX_MATCH)) ? LEN_W'(MAX_MATCH)
                                                           : LEN_W'(len_raw);
    assign fl_dec     = flags_left_reg - 4'd1;

    // token parser
    always_comb begin
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        phase_next      = phase_reg;
        match_low_next  = match_low_reg;
        lit_push        = 1'b0;
        phase_eff       = s_tuser[0] ? PH_FLAG : phase_reg;
        copy_left_next  = copy_left_reg;
        pos_next        = pos_reg;

        if (issue) begin
            copy_left_next = copy_left_reg - LEN_W'(1);
            pos_next       = pos_reg + OFFSET_BITS'(1);
        end

        if (in_acc) begin
            case (phase_eff)
                PH_TOKEN: begin
                    if (flag_bits_reg[0]) begin
                        lit_push        = 1'b1;
                        flag_bits_next  = {1'b0, flag_bits_reg[7:1]};
                        flags_left_next = fl_dec;
                        phase_next      = (fl_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                    end else begin
                        match_low_next = s_tdata;
                        phase_next     = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    copy_left_next  = len_sat;
                    pos_next        = match_word[OFFSET_BITS-1:0];
                    flag_bits_next  = {1'b0, flag_bits_reg[7:1]};
                    flags_left_next = fl_dec;
                    phase_next      = (fl_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                end
                default: begin
                    // flag byte, also the unused phase code
                    flag_bits_next  = s_tdata;
                    flags_left_next = 4'd8;
                    phase_next      = PH_TOKEN;
                end
            endcase
        end
    end

    // window write side, forwarding and clearing pass
    always_comb begin
        push_word.data = rd_pend_reg ? ram_byte : s_tdata;
        push_word.last = rd_pend_reg ? rd_last_reg : 1'b1;

        ram_we    = clr_active_reg | push;
        ram_waddr = clr_active_reg ? clr_addr_reg : wp_reg;
        ram_wdata = clr_active_reg ? '0 : push_word.data;

        wp_next = push ? (wp_reg + WIN_AW'(1)) : wp_reg;
        if (in_acc && s_tuser[0]) begin
            wp_next = WP_START;
        end

        rd_pend_next  = issue;
        rd_last_next  = (copy_left_reg == LEN_W'(1));
        // a read of the entry written in the same cycle sees old data
        fwd_hit_next  = issue && push && (rd_addr == wp_reg);
        fwd_data_next = push_word.data;

        clr_addr_next   = clr_addr_reg + WIN_AW'(1);
        clr_active_next = clr_active_reg && (clr_addr_reg != {WIN_AW{1'b1}});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            wp_reg         <= WP_START;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            phase_reg      <= PH_FLAG;
            match_low_reg  <= '0;
            copy_left_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            wp_reg         <= wp_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            phase_reg      <= phase_next;
            match_low_reg  <= match_low_next;
            copy_left_reg  <= copy_left_next;
            rd_pend_reg    <= rd_pend_next;
            fwd_hit_reg    <= fwd_hit_next;
        end
        pos_reg      <= pos_next;
        rd_last_reg  <= rd_last_next;
        fwd_data_reg <= fwd_data_next;
    end

    lzd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    lzd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_word    (head_word),
        .count     (fifo_cnt)
    );

    assign m_tdata = head_word.data;
    assign m_tlast = head_word.last;

    // queue never overflows: a returning read or a literal always finds room
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_cnt != 2'd2) || pop)
        else $error("output queue overflow");

    // no input taken while a copy is running or a read is in flight
    a_idle_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |-> (copy_left_reg == '0) && !rd_pend_reg && !clr_active_reg)
        else $error("input accepted while busy");

    // queued and in-flight bytes stay within the two queue slots
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        (3'(fifo_cnt) + 3'(rd_pend_reg)) <= 3'd2)
        else $error("credit exceeded");

    // a literal never collides with returning window data
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(lit_push && rd_pend_reg))
        else $error("literal and copy byte in the same cycle");

    // each issued read returns its data in the next cycle
    a_read_return: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> rd_pend_reg && push)
        else $error("window read lost");

endmodule

// ===== rtl/lzd_ram.sv =====
// generic single write port ram with registered read, old data on collision
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store[waddr] <= wdata;
        end
        rdata_reg <= store[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lzd_out_fifo.sv =====
// two-entry output queue feeding the master side
module lzd_out_fifo
    import lzd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_word_t push_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word,
    output logic [1:0] count
);

    out_word_t  ent0_reg, ent0_next;
    out_word_t  ent1_reg, ent1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop = m_valid & m_ready;

    always_comb begin
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        cnt_next  = cnt_reg;
        if (pop && push) begin
            if (cnt_reg == 2'd1) begin
                ent0_next = push_word;
            end else begin
                ent0_next = ent1_reg;
                ent1_next = push_word;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                ent0_next = push_word;
            end else begin
                ent1_next = push_word;
            end
            cnt_next = cnt_reg + 2'd1;
        end else if (pop) begin
            ent0_next = ent1_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign m_word  = ent0_reg;
    assign count   = cnt_reg;

endmodule

// ===== test/tb_lzss_stream_decoder.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the lzss stream decoder: directed and random token streams
module tb_lzss_stream_decoder
    import lzd_pkg::*;
();

    localparam int WIN_SZ       = 1024;
    localparam int MAX_LEN      = 64;
    localparam int OFS_W        = 10;
    localparam int MIN_LEN      = 2;
    localparam int RESTART_WP   = WIN_SZ - MAX_LEN;
    localparam int RAND_WORDS   = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    // watchdog limit, above the clearing pass after reset and the long hold
    localparam int WDOG_LIMIT   = 4000;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] data;
    } comp_word_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;   // [7:0] in_byte
    logic [0:0]        s_tuser  = '0;   // [0] stream_start
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;         // [7:0] dec_byte
    logic              m_tlast;         // run_last

    // predictor state: history window and token parser
    logic [BYTE_W-1:0] hist_mem [WIN_SZ];
    int unsigned       hist_wp;
    logic [7:0]        tok_flags;
    logic [3:0]        tok_left;
    logic [1:0]        tok_phase;
    logic [7:0]        match_lo;

    out_word_t   exp_q [$];
    comp_word_t  pend_q [$];
    int unsigned n_pushed;
    int unsigned err_cnt  = 0;
    int unsigned idle_cyc = 0;
    logic        hold_req = 1'b0;

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    logic [7:0]  rx_cnt     = '0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;

    lzss_stream_decoder #(
        .WINDOW_SIZE (WIN_SZ),
        .MAX_MATCH   (MAX_LEN),
        .OFFSET_BITS (OFS_W),
        .MIN_MATCH   (MIN_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic void hist_put(input logic [7:0] b, input logic last);
        out_word_t w;
        w.data = b;
        w.last = last;
        exp_q.push_back(w);
        hist_mem[hist_wp] = b;
        hist_wp = (hist_wp + 1) % WIN_SZ;
    endfunction

    function automatic void token_used();
        tok_flags = tok_flags >> 1;
        tok_left  = tok_left - 4'd1;
        tok_phase = (tok_left == 4'd0) ? PH_FLAG : PH_TOKEN;
    endfunction

    // works out the decoded bytes that one compressed word causes
    function automatic void lzss_expand(input comp_word_t cw);
        logic [15:0] mword;
        int unsigned pos;
        int unsigned len;
        if (cw.start) begin
            tok_phase = PH_FLAG;
            tok_left  = 4'd0;
            hist_wp   = RESTART_WP;
        end
        case (tok_phase)
            PH_TOKEN: begin
                if (tok_flags[0]) begin
                    hist_put(cw.data, 1'b1);
                    token_used();
                end else begin
                    match_lo  = cw.data;
                    tok_phase = PH_HIGH;
                end
            end
            PH_HIGH: begin
                mword = {cw.data, match_lo};
                pos   = mword & ((1 << OFS_W) - 1);
                len   = (mword >> OFS_W) + MIN_LEN + 1;
                if (len > MAX_LEN)
                    len = MAX_LEN;
                // byte by byte, so an overlapping copy sees what it just wrote
                for (int unsigned k = 0; k < len; k++) begin
                    hist_put(hist_mem[pos % WIN_SZ], k == len - 1);
                    pos = (pos + 1) & ((1 << OFS_W) - 1);
                end
                token_used();
            end
            default: begin
                tok_flags = cw.data;
                tok_left  = 4'd8;
                tok_phase = PH_TOKEN;
            end
        endcase
    endfunction

    function automatic void push_item(input logic [7:0] b, input logic st);
        comp_word_t cw;
        cw.data = b;
        cw.start = st;
        pend_q.push_back(cw);
        n_pushed++;
    endfunction

    task automatic report_err(input string what, input logic [8:0] want, input logic [8:0] got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch %0d on %s: expected %h, got %h", err_cnt, what, want, got);
    endtask

    // sender: bursts of words with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                lzss_expand(pend_q.pop_front());
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pend_q[0].data;
                    s_tuser  <= pend_q[0].start;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each word, stalls on a rotating pattern plus one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (exp_q.size() == 0) begin
                    report_err("unexpected word", 9'h000, {m_tlast, m_tdata});
                end else begin
                    if (m_tdata !== exp_q[0].data)
                        report_err("dec_byte", {1'b0, exp_q[0].data}, {1'b0, m_tdata});
                    if (m_tlast !== exp_q[0].last)
                        report_err("run_last", {8'h00, exp_q[0].last}, {8'h00, m_tlast});
                    void'(exp_q.pop_front());
                end
            end
            rx_cnt <= rx_cnt + 8'd1;
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_cnt[7:6])
                    2'd0:    m_tready <= 1'b1;
                    2'd1:    m_tready <= 1'($urandom_range(0, 1));
                    2'd2:    m_tready <= (rx_cnt[1:0] == 2'd0);
                    default: m_tready <= (rx_cnt[2:0] != 3'd7);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
    end

    initial begin
        while (idle_cyc < WDOG_LIMIT)
            @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int unsigned gen_wp;
        int unsigned code;
        int unsigned pos;
        logic [7:0]  flags;
        logic [15:0] mword;
        bit          need_start;
        bit          st;

        foreach (hist_mem[i])
            hist_mem[i] = '0;
        hist_wp   = RESTART_WP;
        tok_flags = '0;
        tok_left  = '0;
        tok_phase = PH_FLAG;
        match_lo  = '0;
        n_pushed  = 0;

        // match, three literals, three matches, literal
        push_item(8'h8E, 1'b1);
        push_item(8'h00, 1'b0);   // copy from the cleared window
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'hA5, 1'b0);
        push_item(8'hC5, 1'b0);   // overlapping copy, length saturates
        push_item(8'hFF, 1'b0);
        push_item(8'hFC, 1'b0);   // copy wraps round the window end
        push_item(8'h17, 1'b0);
        push_item(8'h00, 1'b0);   // length exactly the maximum
        push_item(8'hF4, 1'b0);
        push_item(8'h5A, 1'b0);
        // fresh flag after eight tokens, then restart halfway through a match
        push_item(8'h00, 1'b0);
        push_item(8'h33, 1'b0);
        push_item(8'hFF, 1'b1);
        push_item(8'h12, 1'b0);
        push_item(8'h34, 1'b0);
        // restart between literals; window survives the restart
        push_item(8'h00, 1'b1);
        push_item(8'hC0, 1'b0);
        push_item(8'h03, 1'b0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // let everything drain before the random part
        while (pend_q.size() != 0 || exp_q.size() != 0)
            @(posedge aclk);
        @(negedge aclk);

        n_pushed   = 0;
        gen_wp     = RESTART_WP;
        need_start = 1'b1;
        while (n_pushed < RAND_WORDS) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4))
                    push_item(8'($urandom), $urandom_range(0, 3) == 0);
                need_start = 1'b1;
            end else begin
                st = need_start || ($urandom_range(0, 9) == 0);
                flags = 8'($urandom);
                push_item(flags, st);
                if (st)
                    gen_wp = RESTART_WP;
                need_start = 1'b0;
                for (int t = 0; t < 8; t++) begin
                    // broken block: stop short, next block restarts
                    if ($urandom_range(0, 15) == 0) begin
                        need_start = 1'b1;
                        break;
                    end
                    if (flags[t]) begin
                        push_item(8'($urandom), 1'b0);
                        gen_wp = (gen_wp + 1) % WIN_SZ;
                    end else begin
                        case ($urandom_range(0, 19))
                            0:       code = 63;
                            1:       code = $urandom_range(6, 62);
                            default: code = $urandom_range(0, 4);
                        endcase
                        if ($urandom_range(0, 4) == 0)
                            pos = $urandom_range(0, WIN_SZ - 1);
                        else
                            pos = (gen_wp + WIN_SZ - $urandom_range(1, 40)) % WIN_SZ;
                        mword = 16'(pos | (code << OFS_W));
                        push_item(mword[7:0], 1'b0);
                        push_item(mword[15:8], 1'b0);
                        gen_wp = (gen_wp + ((code + MIN_LEN + 1 > MAX_LEN) ?
                                  MAX_LEN : code + MIN_LEN + 1)) % WIN_SZ;
                    end
                end
            end
        end
        // receiver holds off while the sender keeps offering
        hold_req <= 1'b1;

        while (pend_q.size() != 0 || exp_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lzd_pkg.sv
rtl/lzd_ram.sv
rtl/lzd_out_fifo.sv
rtl/lzss_stream_decoder.sv
test/tb_lzss_stream_decoder.sv
